// File: design/ssp_pkg.sv
// shared types and constants for the single-source shortest path block
package ssp_pkg;

	localparam int DIST_BITS         = 24;
	localparam int WEIGHT_IN_BITS    = 16;
	localparam int VERTEX_FIELD_BITS = 4;
	localparam int CFG_DATA_BITS     = 5;
	localparam int MAX_VERTICES_DEF  = 16;
	localparam int WEIGHT_BITS_DEF   = 16;

	localparam logic signed [DIST_BITS-1:0] DIST_MAX = 24'sh7FFFFF;
	localparam logic signed [DIST_BITS-1:0] DIST_MIN = -24'sh7FFFFF - 24'sd1;

	localparam logic [CFG_DATA_BITS-1:0] VERTEX_COUNT_RST = 5'd16;

	localparam logic CFG_VERTEX_COUNT  = 1'b0;
	localparam logic CFG_SOURCE_VERTEX = 1'b1;

	localparam logic OP_WRITE_EDGE = 1'b0;
	localparam logic OP_RUN        = 1'b1;

	typedef struct packed {
		logic                              operation;
		logic [VERTEX_FIELD_BITS-1:0]      from_vertex;
		logic [VERTEX_FIELD_BITS-1:0]      to_vertex;
		logic signed [WEIGHT_IN_BITS-1:0]  weight;
		logic                              edge_present;
	} ssp_item_t;

	typedef struct packed {
		logic [VERTEX_FIELD_BITS-1:0] vertex;
		logic signed [DIST_BITS-1:0]  distance;
		logic                         reachable;
		logic [VERTEX_FIELD_BITS-1:0] parent;
		logic                         has_parent;
		logic                         negative_cycle;
		logic                         last;
	} ssp_result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_ROW,
		ST_LOADU,
		ST_SCAN,
		ST_PREP,
		ST_EMIT,
		ST_NEG
	} ssp_state_t;

endpackage

// File: design/ssp_ram.sv
// generic single-write, single-read ram with registered read data
module ssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/single_source_shortest_path.sv
// single-source shortest path engine (bellman-ford) over a stored adjacency matrix
//
// Usage: an item is taken when start is high and busy is low. A write item (operation 0)
// loads one adjacency entry: a weight with the present bit set, or no edge. A run item
// (operation 1) relaxes every vertex pair of the vertex_count vertices whose tail vertex
// is reached, through one shared add-saturate-compare unit, one pair per cycle, row by
// row. A row whose tail vertex is not yet reached is skipped; a reached row fetches the
// tail distance, primes the memory reads, then takes its n pairs. There are n-1 relaxation
// passes and one check pass. The results come out one per cycle on result, each marked
// by result_valid for exactly one cycle; the receiver cannot hold them off. Either n rows
// (vertex 0 first, last on the final row) or a single negative_cycle row appear. After
// reset the adjacency memory is swept to "no edge", one entry a cycle, through all
// 2^(2*ceil(log2(MAX_VERTICES))) entries (256 by default), with busy high; configuration
// writes are taken at any time and must only be made while the block is idle.
module single_source_shortest_path #(
	parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item transfer
	input  logic                               start,
	output logic                               busy,
	input  ssp_pkg::ssp_item_t                 item,
	// result transfer
	output logic                               result_valid,
	output ssp_pkg::ssp_result_t               result,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [ssp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import ssp_pkg::*;

	// vertex index width, count width, adjacency address width
	localparam int VB   = $clog2(MAX_VERTICES);
	localparam int NW   = $clog2(MAX_VERTICES + 1);
	localparam int EAW  = 2 * VB;
	localparam int VDEP = 1 << VB;
	localparam int EDEP = 1 << EAW;
	localparam int DB   = DIST_BITS;
	localparam int WB   = WEIGHT_BITS;
	// sum of a distance and a weight, one bit of headroom
	localparam int SUMW = ((DB > WB) ? DB : WB) + 1;

	// clamp limits for incoming weights
	localparam logic signed [32:0] W_HI = (33'sd1 <<< (WB - 1)) - 33'sd1;
	localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

	localparam logic signed [SUMW-1:0] SUM_DMAX = SUMW'(DIST_MAX);
	localparam logic signed [SUMW-1:0] SUM_DMIN = SUMW'(DIST_MIN);

	// sequencer and counters
	ssp_state_t state_q, state_d;
	logic [EAW-1:0]          clr_q;
	logic [VB-1:0]           pass_q;
	logic [VB-1:0]           u_q;
	logic [VB-1:0]           v_q;
	logic [VB-1:0]           v_nxt;
	logic [MAX_VERTICES-1:0] reached_q;
	logic [MAX_VERTICES-1:0] hasp_q;
	logic signed [DB-1:0]    du_q;

	// configuration
	logic [CFG_DATA_BITS-1:0]     vc_q;
	logic [VERTEX_FIELD_BITS-1:0] src_q;
	logic [NW-1:0]                n_w;
	logic                         src_ok;

	// result register
	ssp_result_t res_d, result_q;
	logic        res_valid_d, result_valid_q;

	// memory ports
	logic           edge_we;
	logic [EAW-1:0] edge_waddr, edge_raddr;
	logic [WB:0]    edge_wdata, edge_rdata;
	logic           dist_we;
	logic [VB-1:0]  dist_waddr, dist_raddr;
	logic [DB-1:0]  dist_wdata, dist_rdata;
	logic           par_we;
	logic [VB-1:0]  par_waddr;
	logic [VB-1:0]  par_wdata, par_rdata;

	// shared relax unit
	logic signed [WB-1:0]   edge_w;
	logic                   edge_ok;
	logic signed [DB-1:0]   dv_s;
	logic signed [SUMW-1:0] sum_w;
	logic signed [DB-1:0]   sat_d;
	logic                   v_reached;
	logic                   relax_hit;
	logic                   chk_hit;

	// loop bounds
	logic u_last, v_last, check_pass, u_reached;

	// write item decode
	logic                   item_take;
	logic                   edge_take;
	logic signed [32:0]     w_in;
	logic signed [WB-1:0]   w_clamp;

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign item_take = start && !busy;
	assign edge_take = item_take && (item.operation == OP_WRITE_EDGE)
		&& (32'(item.from_vertex) < 32'(MAX_VERTICES))
		&& (32'(item.to_vertex) < 32'(MAX_VERTICES));

	// weight clamped to the stored width
	always_comb begin
		w_in = 33'($signed(item.weight));
		if (w_in > W_HI) begin
			w_clamp = WB'(W_HI);
		end else if (w_in < W_LO) begin
			w_clamp = WB'(W_LO);
		end else begin
			w_clamp = WB'(w_in);
		end
	end

	// vertex count limited to 1..MAX_VERTICES
	always_comb begin
		if (vc_q == '0) begin
			n_w = NW'(1);
		end else if (32'(vc_q) > 32'(MAX_VERTICES)) begin
			n_w = NW'(MAX_VERTICES);
		end else begin
			n_w = NW'(vc_q);
		end
	end

	// a source beyond the vertex count reaches nothing
	assign src_ok = (32'(src_q) < 32'(n_w));

	assign v_nxt      = v_q + 1'b1;
	assign u_last     = (NW'(u_q) == (n_w - NW'(1)));
	assign v_last     = (NW'(v_q) == (n_w - NW'(1)));
	assign check_pass = (NW'(pass_q) == (n_w - NW'(1)));
	assign u_reached  = reached_q[u_q];
	assign v_reached  = reached_q[v_q];

	// one add, saturate and compare per cycle
	always_comb begin
		edge_ok = edge_rdata[WB];
		edge_w  = $signed(edge_rdata[WB-1:0]);
		dv_s    = $signed(dist_rdata);
		sum_w   = SUMW'(du_q) + SUMW'(edge_w);
		if (sum_w > SUM_DMAX) begin
			sat_d = DIST_MAX;
		end else if (sum_w < SUM_DMIN) begin
			sat_d = DIST_MIN;
		end else begin
			sat_d = DB'(sum_w);
		end
		// relaxation compares the saturated sum, the check pass the full one
		relax_hit = edge_ok && (!v_reached || (SUMW'(sat_d) < SUMW'(dv_s)));
		chk_hit   = edge_ok && (!v_reached || (sum_w < SUMW'(dv_s)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_take && (item.operation == OP_RUN)) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = ST_ROW;
			end
			ST_ROW: begin
				if (u_reached) begin
					state_d = ST_LOADU;
				end else if (u_last && check_pass) begin
					state_d = ST_PREP;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_LOADU: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (check_pass && chk_hit) begin
					state_d = ST_NEG;
				end else if (v_last) begin
					state_d = (u_last && check_pass) ? ST_PREP : ST_ROW;
				end
			end
			ST_PREP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (v_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_NEG: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory controls and result formatting
	always_comb begin
		edge_we     = 1'b0;
		edge_waddr  = {VB'(item.from_vertex), VB'(item.to_vertex)};
		edge_wdata  = {item.edge_present, w_clamp};
		edge_raddr  = {u_q, v_nxt};
		dist_we     = 1'b0;
		dist_waddr  = v_q;
		dist_wdata  = sat_d;
		dist_raddr  = v_nxt;
		par_we      = 1'b0;
		par_waddr   = v_q;
		par_wdata   = u_q;
		res_valid_d = 1'b0;
		res_d       = '0;
		case (state_q)
			ST_CLEAR: begin
				edge_we    = 1'b1;
				edge_waddr = clr_q;
				edge_wdata = '0;
			end
			ST_IDLE: begin
				edge_we = edge_take;
			end
			ST_INIT: begin
				// source starts at distance zero
				dist_we    = src_ok;
				dist_waddr = VB'(src_q);
				dist_wdata = '0;
			end
			ST_ROW: begin
				dist_raddr = u_q;
			end
			ST_LOADU: begin
				edge_raddr = {u_q, VB'(0)};
				dist_raddr = '0;
			end
			ST_SCAN: begin
				dist_we = !check_pass && relax_hit;
				par_we  = !check_pass && relax_hit;
			end
			ST_PREP: begin
				dist_raddr = '0;
			end
			ST_EMIT: begin
				res_valid_d       = 1'b1;
				res_d.vertex      = VERTEX_FIELD_BITS'(v_q);
				res_d.distance    = v_reached ? $signed(dist_rdata) : DIST_MAX;
				res_d.reachable   = v_reached;
				res_d.parent      = hasp_q[v_q] ? VERTEX_FIELD_BITS'(par_rdata) : '0;
				res_d.has_parent  = hasp_q[v_q];
				res_d.last        = v_last;
			end
			ST_NEG: begin
				res_valid_d          = 1'b1;
				res_d.negative_cycle = 1'b1;
				res_d.last           = 1'b1;
			end
			default: begin
				res_valid_d = 1'b0;
			end
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pass_q    <= '0;
			u_q       <= '0;
			v_q       <= '0;
			reached_q <= '0;
			hasp_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_INIT: begin
					// only the source starts out reached
					reached_q <= src_ok ? (MAX_VERTICES'(1) << src_q) : '0;
					hasp_q    <= '0;
					pass_q    <= '0;
					u_q       <= '0;
				end
				ST_ROW: begin
					// unreached tail vertex: skip the whole row
					if (!u_reached) begin
						if (u_last) begin
							u_q <= '0;
							if (!check_pass) begin
								pass_q <= pass_q + 1'b1;
							end
						end else begin
							u_q <= u_q + 1'b1;
						end
					end
				end
				ST_LOADU: begin
					v_q <= '0;
				end
				ST_SCAN: begin
					if (!check_pass && relax_hit) begin
						reached_q[v_q] <= 1'b1;
						hasp_q[v_q]    <= 1'b1;
					end
					if (v_last) begin
						if (u_last) begin
							u_q <= '0;
							if (!check_pass) begin
								pass_q <= pass_q + 1'b1;
							end
						end else begin
							u_q <= u_q + 1'b1;
						end
					end else begin
						v_q <= v_nxt;
					end
				end
				ST_PREP: begin
					v_q <= '0;
				end
				ST_EMIT: begin
					v_q <= v_nxt;
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// tail distance, kept current when a self loop lowers it
	always_ff @(posedge clk) begin
		if (state_q == ST_LOADU) begin
			du_q <= $signed(dist_rdata);
		end else if ((state_q == ST_SCAN) && dist_we && (v_q == u_q)) begin
			du_q <= sat_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q  <= VERTEX_COUNT_RST;
			src_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VERTEX_COUNT: begin
					vc_q <= cfg_data;
				end
				CFG_SOURCE_VERTEX: begin
					src_q <= cfg_data[VERTEX_FIELD_BITS-1:0];
				end
				default: begin
					vc_q <= vc_q;
				end
			endcase
		end
	end

	// result strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_d) begin
			result_q <= res_d;
		end
	end

	// adjacency: present bit over weight
	ssp_ram #(
		.WIDTH(WB + 1),
		.DEPTH(EDEP)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// per-vertex distances
	ssp_ram #(
		.WIDTH(DB),
		.DEPTH(VDEP)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// per-vertex parents, read alongside the distances
	ssp_ram #(
		.WIDTH(VB),
		.DEPTH(VDEP)
	) u_par_ram (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (dist_raddr),
		.rdata (par_rdata)
	);

`ifndef SYNTHESIS
	// a negative cycle report is always the whole run
	a_neg_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.negative_cycle |-> result.last)
		else $error("negative cycle result without last");

	// nothing follows the final result of a run
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result strobe after last");

	// a recorded parent implies the vertex was reached
	a_parent_reached: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.has_parent |-> result.reachable)
		else $error("parent on unreachable vertex");

	// every relaxation marks its head vertex reached
	a_relax_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && dist_we |=> reached_q[$past(v_q)])
		else $error("relaxed vertex not marked reached");

	// a run transfer makes the block busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.operation == OP_RUN) |=> busy)
		else $error("run item did not start");
`endif

endmodule

// File: bench/single_source_shortest_path_tb.sv
// self-checking testbench for the single-source shortest path block
module single_source_shortest_path_tb;

	import ssp_pkg::*;

	// vertex limit of the default build and the size of the adjacency matrix
	localparam int MAX_V = MAX_VERTICES_DEF;
	localparam int ARCS  = MAX_V * MAX_V;
	// rough number of items after which random graphs stop being generated
	localparam int ITEM_TARGET = 140;
	// even if every item were a sixteen-vertex run with the longest gap in front of it, this
	// leaves several times the margin
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	// cycles allowed after the last row for a write item to finish inside the block
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	ssp_item_t   item;
	logic        result_valid;
	ssp_result_t result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// golden copy of the block's state
	bit  arc_live [ARCS];
	int  arc_weight [ARCS];
	logic [CFG_DATA_BITS-1:0]     cfg_vertices;
	logic [VERTEX_FIELD_BITS-1:0] cfg_origin;

	// rows still owed by the block, oldest first
	ssp_result_t path_rows [$];

	int          mismatches = 0;
	int          rows_seen = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	// when set the sender issues items with no gaps between them
	bit          steady;

	single_source_shortest_path DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// hard stop in case the block hangs or drops rows
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d rows outstanding", cycle_count,
				path_rows.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic note_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("row %0d %s: got %0d, expected %0d", rows_seen, name,
				got, want));
	endtask

	// vertex count as the block uses it: zero acts as one, anything past the limit as the limit
	function automatic int active_vertices();
		if (cfg_vertices == 0)
			return 1;
		if (cfg_vertices > MAX_V)
			return MAX_V;
		return cfg_vertices;
	endfunction

	// apply one accepted item to the golden state; a run queues the rows it must produce
	function automatic void absorb_item(input ssp_item_t it);
		int          n;
		int          u;
		int          v;
		int          pass_no;
		int          arc;
		longint      best [MAX_V];
		bit          reached [MAX_V];
		int          via [MAX_V];
		bit          has_via [MAX_V];
		bit          looped;
		longint      sum;
		ssp_result_t row;
		if (it.operation == OP_WRITE_EDGE) begin
			// weight field is as wide as the stored weight, so no clamping is needed
			arc = {it.from_vertex, it.to_vertex};
			arc_live[arc] = it.edge_present;
			if (it.edge_present)
				arc_weight[arc] = $signed(it.weight);
			return;
		end
		n = active_vertices();
		for (u = 0; u < MAX_V; u++) begin
			best[u] = DIST_MAX;
			reached[u] = 1'b0;
			via[u] = 0;
			has_via[u] = 1'b0;
		end
		// a source beyond the vertex count leaves everything unreached
		if (cfg_origin < n) begin
			reached[cfg_origin] = 1'b1;
			best[cfg_origin] = 0;
		end
		// in-place relaxation: an update made earlier in a pass is seen later in it
		for (pass_no = 1; pass_no < n; pass_no++) begin
			for (u = 0; u < n; u++) begin
				if (reached[u]) begin
					for (v = 0; v < n; v++) begin
						arc = u * MAX_V + v;
						if (arc_live[arc]) begin
							sum = best[u] + arc_weight[arc];
							if (sum > DIST_MAX)
								sum = DIST_MAX;
							else if (sum < DIST_MIN)
								sum = DIST_MIN;
							if (!reached[v] || sum < best[v]) begin
								best[v] = sum;
								reached[v] = 1'b1;
								via[v] = u;
								has_via[v] = 1'b1;
							end
						end
					end
				end
			end
		end
		// check pass works on the unsaturated sum so a pinned distance cannot hide a cycle
		looped = 1'b0;
		for (u = 0; u < n; u++) begin
			if (reached[u]) begin
				for (v = 0; v < n; v++) begin
					arc = u * MAX_V + v;
					if (arc_live[arc]) begin
						sum = best[u] + arc_weight[arc];
						if (!reached[v] || sum < best[v])
							looped = 1'b1;
					end
				end
			end
		end
		if (looped) begin
			row = '0;
			row.negative_cycle = 1'b1;
			row.last = 1'b1;
			path_rows.push_back(row);
			return;
		end
		for (v = 0; v < n; v++) begin
			row = '0;
			row.vertex = v[VERTEX_FIELD_BITS-1:0];
			row.distance = reached[v] ? DIST_BITS'(best[v]) : DIST_MAX;
			row.reachable = reached[v];
			row.parent = has_via[v] ? via[v][VERTEX_FIELD_BITS-1:0] : '0;
			row.has_parent = has_via[v];
			row.last = (v == n - 1);
			path_rows.push_back(row);
		end
	endfunction

	// each row on the result port is compared against the oldest one still owed
	always @(posedge clk) begin : check_rows
		ssp_result_t want;
		if (arst_n && result_valid) begin
			if (path_rows.size() == 0) begin
				note_mismatch($sformatf("row %0d arrived with nothing pending", rows_seen));
			end else begin
				want = path_rows.pop_front();
				compare_field("vertex", result.vertex, want.vertex);
				compare_field("distance", result.distance, want.distance);
				compare_field("reachable", result.reachable, want.reachable);
				compare_field("parent", result.parent, want.parent);
				compare_field("has_parent", result.has_parent, want.has_parent);
				compare_field("negative_cycle", result.negative_cycle, want.negative_cycle);
				compare_field("last", result.last, want.last);
			end
			rows_seen++;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one item transfer; start may be left high so that the next item follows at once
	task automatic send_item(input ssp_item_t it);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		absorb_item(it);
		items_sent++;
	endtask

	task automatic write_arc(input int from, input int to, input int w, input bit present);
		ssp_item_t it;
		it.operation = OP_WRITE_EDGE;
		it.from_vertex = from[VERTEX_FIELD_BITS-1:0];
		it.to_vertex = to[VERTEX_FIELD_BITS-1:0];
		it.weight = w[WEIGHT_IN_BITS-1:0];
		it.edge_present = present;
		send_item(it);
	endtask

	// the unused fields of a run carry random values
	task automatic run_paths();
		ssp_item_t it;
		it.operation = OP_RUN;
		it.from_vertex = VERTEX_FIELD_BITS'($urandom_range(0, 15));
		it.to_vertex = VERTEX_FIELD_BITS'($urandom_range(0, 15));
		it.weight = WEIGHT_IN_BITS'($urandom_range(0, 65535));
		it.edge_present = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// sender pause: hold off until every owed row is in, then let the block go idle
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (path_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register transfer; only called while the block is idle
	task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		start <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_VERTEX_COUNT)
			cfg_vertices = data;
		else
			cfg_origin = data[VERTEX_FIELD_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly small non-negative weights, some negative, a few anywhere or at the extremes
	function automatic int pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 200);
		if (r < 80)
			return -int'($urandom_range(1, 20));
		if (r < 90)
			return int'($urandom_range(0, 65535)) - 32768;
		return $urandom_range(0, 1) ? 32767 : -32768;
	endfunction

	// drop every negative edge among the active vertices so the next run yields a table
	task automatic clear_negative_arcs();
		int n;
		int u;
		int v;
		n = active_vertices();
		for (u = 0; u < n; u++)
			for (v = 0; v < n; v++)
				if (arc_live[u * MAX_V + v] && arc_weight[u * MAX_V + v] < 0)
					write_arc(u, v, pick_weight(), 1'b0);
	endtask

	// straight after reset: no edges, sixteen vertices, source 0
	task automatic test_empty_graph();
		run_paths();
	endtask

	// full-scale weights, a two-vertex negative cycle, then edge removal and a zero weight
	task automatic test_weight_extremes();
		write_arc(0, 15, 32767, 1'b1);
		write_arc(15, 0, -32768, 1'b1);
		run_paths();
		write_arc(15, 0, 0, 1'b0);
		write_arc(15, 7, -32768, 1'b1);
		write_arc(7, 3, 0, 1'b1);
		run_paths();
	endtask

	// zero acts as one vertex, values past the limit as sixteen
	task automatic test_vertex_count_limits();
		settle();
		write_reg(CFG_VERTEX_COUNT, 5'd0);
		write_arc(0, 0, -1, 1'b1);
		run_paths();
		write_arc(0, 0, 5, 1'b1);
		run_paths();
		settle();
		write_reg(CFG_VERTEX_COUNT, 5'd31);
		write_reg(CFG_SOURCE_VERTEX, 5'd15);
		run_paths();
	endtask

	// source at or past the vertex count: every row unreached
	task automatic test_source_out_of_range();
		settle();
		write_reg(CFG_VERTEX_COUNT, 5'd4);
		// upper data bit is not part of the source register
		write_reg(CFG_SOURCE_VERTEX, 5'b11001);
		run_paths();
		settle();
		write_reg(CFG_SOURCE_VERTEX, 5'd4);
		run_paths();
	endtask

	// writes and a run issued with no gaps at all
	task automatic test_back_to_back();
		settle();
		write_reg(CFG_VERTEX_COUNT, 5'd3);
		write_reg(CFG_SOURCE_VERTEX, 5'd0);
		steady = 1'b1;
		write_arc(0, 1, 5, 1'b1);
		write_arc(1, 2, -3, 1'b1);
		write_arc(0, 2, 4, 1'b1);
		run_paths();
		steady = 1'b0;
	endtask

	// ring plus self-loops of near-minimum weight: distances fall far enough to saturate
	task automatic test_saturating_ring();
		int v;
		settle();
		write_reg(CFG_VERTEX_COUNT, 5'd16);
		write_reg(CFG_SOURCE_VERTEX, 5'd0);
		for (v = 0; v < MAX_V; v++) begin
			write_arc(v, (v + 1) % MAX_V, int'($urandom_range(0, 768)) - 32768, 1'b1);
			write_arc(v, v, int'($urandom_range(0, 768)) - 32768, 1'b1);
		end
		run_paths();
	endtask

	// random graphs: now and then new settings, a handful of edge writes, then a run
	task automatic test_random_graphs();
		int n;
		int r;
		int w;
		logic [CFG_DATA_BITS-1:0] count_code;
		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1) == 0) begin
				settle();
				r = $urandom_range(0, 99);
				if (r < 12)
					n = MAX_V;
				else if (r < 22)
					n = $urandom_range(7, 15);
				else
					n = $urandom_range(1, 6);
				count_code = CFG_DATA_BITS'(n);
				// the aliases of the extreme counts
				if (n == MAX_V && $urandom_range(0, 1))
					count_code = CFG_DATA_BITS'($urandom_range(17, 31));
				else if (n == 1 && $urandom_range(0, 1))
					count_code = 5'd0;
				write_reg(CFG_VERTEX_COUNT, count_code);
				if ($urandom_range(0, 99) < 85)
					r = $urandom_range(0, n - 1);
				else
					r = $urandom_range(0, 15);
				write_reg(CFG_SOURCE_VERTEX, {1'($urandom_range(0, 1)), 4'(r)});
			end
			n = active_vertices();
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: anywhere in the matrix, any weight
					w = int'($urandom_range(0, 65535)) - 32768;
					write_arc($urandom_range(0, 15), $urandom_range(0, 15), w,
						1'($urandom_range(0, 1)));
				end else begin
					write_arc($urandom_range(0, n - 1), $urandom_range(0, n - 1),
						pick_weight(), $urandom_range(0, 9) != 0);
				end
			end
			if ($urandom_range(0, 1))
				clear_negative_arcs();
			if ($urandom_range(0, 4) == 0)
				settle();
			run_paths();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_VERTEX_COUNT;
		cfg_data = '0;
		steady = 1'b0;
		// golden state after reset
		cfg_vertices = VERTEX_COUNT_RST;
		cfg_origin = '0;
		foreach (arc_live[i]) begin
			arc_live[i] = 1'b0;
			arc_weight[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the first item waits out the clearing sweep of the adjacency memory
		test_empty_graph();
		test_weight_extremes();
		test_vertex_count_limits();
		test_source_out_of_range();
		test_back_to_back();
		test_saturating_ring();
		test_random_graphs();

		// every owed row in, then a short tail for stray output
		settle();
		repeat (24) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
design/ssp_pkg.sv
design/ssp_ram.sv
design/single_source_shortest_path.sv
bench/single_source_shortest_path_tb.sv
